// ===== rtl/core/cobs_crc_pkg.sv =====
// Shared types and constants for the COBS/CRC-16 frame encoder.
`default_nettype none

package cobs_crc_pkg;

    // Frame buffer geometry
    localparam int unsigned FRAME_MAX = 1024;
    localparam int unsigned CAP_W     = 11;
    localparam int unsigned ADDR_W    = 10;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // COBS block codes
    localparam logic [7:0] CODE_START  = 8'h01;
    localparam logic [7:0] CODE_BEFORE_FULL = 8'hFE;
    localparam logic [7:0] DELIMITER   = 8'h00;

    // Front-to-back queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input command codes (s_tuser)
    localparam logic FUNC_FEED   = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // One queued command: a payload byte in payload[7:0], or for finish the
    // frame CRC (low byte first on the wire)
    typedef struct packed {
        logic        is_finish;
        logic [15:0] payload;
    } q_entry_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/cobs_crc_front.sv =====
// Front end: accepts input beats, runs the CRC and queues commands.
`default_nettype none

module cobs_crc_front (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,
    input  wire logic [0:0]             s_tuser,
    input  wire cobs_crc_pkg::q_status_t q_status,
    output logic                        push,
    output cobs_crc_pkg::q_entry_t      push_entry
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        accept;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ cobs_crc_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept;

    always_comb begin
        crc_next             = crc_reg;
        push_entry.is_finish = (s_tuser[0] == cobs_crc_pkg::FUNC_FINISH);
        push_entry.payload   = {8'h00, s_tdata};
        if (s_tuser[0] == cobs_crc_pkg::FUNC_FINISH) begin
            // finish carries the CRC as it stood before the command
            push_entry.payload = crc_reg;
            if (accept) begin
                crc_next = cobs_crc_pkg::CRC_INIT;
            end
        end else if (accept) begin
            crc_next = crc16_byte(crc_reg, s_tdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= cobs_crc_pkg::CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cobs_crc_fifo.sv =====
// Short command queue between the front end and the encoder back end.
`default_nettype none

module cobs_crc_fifo (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire cobs_crc_pkg::q_entry_t  push_entry,
    input  wire logic                    pop,
    output cobs_crc_pkg::q_entry_t       head_entry,
    output cobs_crc_pkg::q_status_t      q_status
);

    cobs_crc_pkg::q_entry_t mem_reg [cobs_crc_pkg::QUEUE_DEPTH];

    logic [cobs_crc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [cobs_crc_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [cobs_crc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [cobs_crc_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [cobs_crc_pkg::QCNT_W-1:0] count_reg;
    logic [cobs_crc_pkg::QCNT_W-1:0] count_next;
    logic                            do_push;
    logic                            do_pop;

    assign q_status.full  = (count_reg == cobs_crc_pkg::QCNT_W'(cobs_crc_pkg::QUEUE_DEPTH));
    assign q_status.valid = (count_reg != '0);
    assign head_entry     = mem_reg[rd_ptr_reg];

    assign do_push = push && !q_status.full;
    assign do_pop  = pop && q_status.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = cobs_crc_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = cobs_crc_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = cobs_crc_pkg::QCNT_W'(count_reg + 1'b1);
            2'b01:   count_next = cobs_crc_pkg::QCNT_W'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cobs_crc_back.sv =====
// Back end: COBS sequencer emitting buffer writes and frame status beats.
`default_nettype none

module cobs_crc_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [cobs_crc_pkg::CAP_W-1:0]    frame_capacity,
    input  wire cobs_crc_pkg::q_status_t           q_status,
    input  wire cobs_crc_pkg::q_entry_t            head_entry,
    output logic                                   pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [31:0]                            m_tdata,
    output logic [0:0]                             m_tuser,
    output logic                                   m_tlast
);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_PUT       = 6'b000010,
        ST_CLOSE     = 6'b000100,
        ST_TERM_CODE = 6'b001000,
        ST_DELIM     = 6'b010000,
        ST_STATUS    = 6'b100000
    } back_state_t;

    back_state_t state_reg, state_next;

    cobs_crc_pkg::q_entry_t cur_reg, cur_next;
    logic                   put_sel_reg, put_sel_next;

    logic [cobs_crc_pkg::CAP_W-1:0]  wi_reg, wi_next;
    logic [cobs_crc_pkg::ADDR_W-1:0] ci_reg, ci_next;
    logic [7:0]                      bc_reg, bc_next;
    logic                            ovf_reg, ovf_next;

    logic                            m_valid_reg, m_valid_next;
    logic [31:0]                     m_data_reg, m_data_next;
    logic                            m_status_reg, m_status_next;
    logic                            m_last_reg, m_last_next;

    logic [cobs_crc_pkg::CAP_W-1:0]  cap;
    logic [cobs_crc_pkg::CAP_W-1:0]  wi_inc;
    logic [7:0]                      put_byte;
    logic                            room;
    logic                            out_free;
    logic                            put_done;
    logic                            item_done;

    logic                            emit;
    logic                            e_status;
    logic [cobs_crc_pkg::ADDR_W-1:0] e_addr;
    logic [7:0]                      e_data;
    logic [cobs_crc_pkg::CAP_W-1:0]  e_len;
    logic                            e_ovf;
    logic                            e_last;

    assign cap = (frame_capacity > cobs_crc_pkg::CAP_W'(cobs_crc_pkg::FRAME_MAX))
               ? cobs_crc_pkg::CAP_W'(cobs_crc_pkg::FRAME_MAX) : frame_capacity;
    assign wi_inc   = cobs_crc_pkg::CAP_W'(wi_reg + 1'b1);
    assign put_byte = put_sel_reg ? cur_reg.payload[15:8] : cur_reg.payload[7:0];
    assign room     = (wi_reg < cap);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        put_sel_next = put_sel_reg;
        wi_next      = wi_reg;
        ci_next      = ci_reg;
        bc_next      = bc_reg;
        ovf_next     = ovf_reg;
        pop          = 1'b0;
        put_done     = 1'b0;
        item_done    = 1'b0;
        emit         = 1'b0;
        e_status     = 1'b0;
        e_addr       = '0;
        e_data       = '0;
        e_len        = '0;
        e_ovf        = 1'b0;
        e_last       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                item_done = 1'b1;
            end
            ST_PUT: begin
                if (out_free) begin
                    if (!room) begin
                        ovf_next = 1'b1;
                        put_done = 1'b1;
                    end else if (put_byte == 8'h00) begin
                        // zero byte closes the block: write its code
                        emit     = 1'b1;
                        e_addr   = ci_reg;
                        e_data   = bc_reg;
                        e_last   = !cur_reg.is_finish;
                        ci_next  = wi_reg[cobs_crc_pkg::ADDR_W-1:0];
                        wi_next  = wi_inc;
                        bc_next  = cobs_crc_pkg::CODE_START;
                        put_done = 1'b1;
                    end else begin
                        emit    = 1'b1;
                        e_addr  = wi_reg[cobs_crc_pkg::ADDR_W-1:0];
                        e_data  = put_byte;
                        wi_next = wi_inc;
                        bc_next = bc_reg + 8'd1;
                        if (bc_reg == cobs_crc_pkg::CODE_BEFORE_FULL) begin
                            state_next = ST_CLOSE;
                        end else begin
                            e_last   = !cur_reg.is_finish;
                            put_done = 1'b1;
                        end
                    end
                end
            end
            ST_CLOSE: begin
                // block full at 254 data bytes
                if (out_free) begin
                    emit     = 1'b1;
                    e_addr   = ci_reg;
                    e_data   = bc_reg;
                    e_last   = !cur_reg.is_finish;
                    ci_next  = wi_reg[cobs_crc_pkg::ADDR_W-1:0];
                    wi_next  = wi_inc;
                    bc_next  = cobs_crc_pkg::CODE_START;
                    put_done = 1'b1;
                end
            end
            ST_TERM_CODE: begin
                if (out_free) begin
                    if (room) begin
                        emit       = 1'b1;
                        e_addr     = ci_reg;
                        e_data     = bc_reg;
                        state_next = ST_DELIM;
                    end else begin
                        ovf_next   = 1'b1;
                        state_next = ST_STATUS;
                    end
                end
            end
            ST_DELIM: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_addr     = wi_reg[cobs_crc_pkg::ADDR_W-1:0];
                    e_data     = cobs_crc_pkg::DELIMITER;
                    wi_next    = wi_inc;
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    emit      = 1'b1;
                    e_status  = 1'b1;
                    e_len     = ovf_reg ? '0 : wi_reg;
                    e_ovf     = ovf_reg;
                    e_last    = 1'b1;
                    wi_next   = cobs_crc_pkg::CAP_W'(1);
                    ci_next   = '0;
                    bc_next   = cobs_crc_pkg::CODE_START;
                    ovf_next  = 1'b0;
                    item_done = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (put_done) begin
            if (!cur_reg.is_finish) begin
                item_done = 1'b1;
            end else if (!put_sel_reg) begin
                put_sel_next = 1'b1;
                state_next   = ST_PUT;
            end else begin
                state_next = ST_TERM_CODE;
            end
        end

        // pick up the next command directly, without a pass through ST_IDLE
        if (item_done) begin
            if (q_status.valid) begin
                pop          = 1'b1;
                cur_next     = head_entry;
                put_sel_next = 1'b0;
                state_next   = ST_PUT;
            end else begin
                state_next = ST_IDLE;
            end
        end
    end

    // output register
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        if (out_free) begin
            m_valid_next  = emit;
            m_data_next   = {2'b00, e_ovf, e_len, e_data, e_addr};
            m_status_next = e_status;
            m_last_next   = e_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            put_sel_reg <= 1'b0;
            wi_reg      <= cobs_crc_pkg::CAP_W'(1);
            ci_reg      <= '0;
            bc_reg      <= cobs_crc_pkg::CODE_START;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            put_sel_reg <= put_sel_next;
            wi_reg      <= wi_next;
            ci_reg      <= ci_next;
            bc_reg      <= bc_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_status_reg;
    assign m_tlast    = m_last_reg;

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_status.valid)
        else $error("pop from empty queue");

    // a full block holds code 0xFF only until its code beat goes out
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (bc_reg != 8'h00) && ((bc_reg != 8'hFF) || (state_reg == ST_CLOSE)))
        else $error("block code out of range");

    a_status_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && e_status && out_free)
        |=> (wi_reg == cobs_crc_pkg::CAP_W'(1)) && (bc_reg == cobs_crc_pkg::CODE_START)
            && (ci_reg == '0) && !ovf_reg)
        else $error("frame state not restarted after status");

    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(ovf_reg) |-> $past(state_reg == ST_STATUS))
        else $error("overflow cleared mid-frame");

endmodule

`default_nettype wire

// ===== rtl/core/cobs_crc16_frame_encoder_unit.sv =====
// COBS frame encoder with CRC-16: top level with capacity register.
//
// Input channel (s_): one beat per command. s_tuser[0] = 1 finishes the frame,
// 0 feeds the payload byte in s_tdata. Each byte updates a CRC-16/CCITT-FALSE
// and is COBS-encoded; finish pushes the CRC (low byte first), closes the
// block, writes the 0x00 delimiter and reports the frame.
// Result channel (m_): buffer writes (m_tuser[0] = 0) with address and byte,
// and one status beat per frame (m_tuser[0] = 1) with length or overflow.
// m_tlast marks the last result beat of each command; a byte that finds no
// room yields no beat at all.
// An input beat passes through the command queue, the sequencer's command
// register and the output register before it shows on m_tvalid.
// Throughput: the sequencer emits at most one result per cycle unless m_tready
// stalls it; a byte that fills a 254-byte block also writes the block's code.
// A 4-entry command queue decouples intake from the sequencer, so input
// beats keep flowing while the output register waits on m_tready; s_tready
// drops only when the queue is full.
// Reset clears the queue, CRC and frame state, sets the capacity to 1024;
// cfg_we loads a new capacity; the user uses it only while idle (unchecked).
`default_nettype none

module cobs_crc16_frame_encoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata,   // frame_capacity
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // data_byte
    input  wire logic [0:0]  s_tuser,     // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,     // write_addr[9:0], write_data[17:10],
                                          // frame_len[28:18], overflow[29], zero
    output logic [0:0]       m_tuser,     // is_status
    output logic             m_tlast
);

    logic [cobs_crc_pkg::CAP_W-1:0] capacity_reg;
    logic [cobs_crc_pkg::CAP_W-1:0] capacity_next;

    cobs_crc_pkg::q_status_t q_status;
    cobs_crc_pkg::q_entry_t  push_entry;
    cobs_crc_pkg::q_entry_t  head_entry;
    logic                    push;
    logic                    pop;

    always_comb begin
        capacity_next = capacity_reg;
        if (cfg_we) begin
            capacity_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= cobs_crc_pkg::CAP_W'(cobs_crc_pkg::FRAME_MAX);
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    cobs_crc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    cobs_crc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    cobs_crc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .frame_capacity (capacity_reg),
        .q_status       (q_status),
        .head_entry     (head_entry),
        .pop            (pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

endmodule

`default_nettype wire
